[rtl/humidity_temp_frame_decoder_macros.svh]
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define HTFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/htfd_pkg.sv]
package htfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  localparam logic [14:0] TEMP_SPAN  = 15'd17500;
  localparam logic [13:0] HUMID_SPAN = 14'd10000;
  localparam logic [16:0] RAW_FULL   = 17'd65535;
  localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;

  localparam logic signed [14:0] TEMP_MIN_RST  = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX_RST  = 15'sd12500;
  localparam logic [13:0]        HUMID_MIN_RST = 14'd0;
  localparam logic [13:0]        HUMID_MAX_RST = 14'd10000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TEMP_CRC  = 2'd1,
    ST_HUMID_CRC = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_TEMP_MIN  = 2'd0,
    REG_TEMP_MAX  = 2'd1,
    REG_HUMID_MIN = 2'd2,
    REG_HUMID_MAX = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] temp_bits;
    logic [15:0] humid_bits;
  } frame_t;

  typedef struct packed {
    logic signed [14:0] temp_min;
    logic signed [14:0] temp_max;
    logic [13:0]        humid_min;
    logic [13:0]        humid_max;
  } limits_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[rtl/htfd_if.sv]
interface htfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface htfd_result_if import htfd_pkg::*; ();
  logic               valid;
  logic               ready;
  status_e            status;
  logic signed [14:0] temp_centi;
  logic [13:0]        humid_centi;
  logic [15:0]        temp_raw_word;
  logic [15:0]        humid_raw_word;
  logic               temp_out_of_range;
  logic               humid_out_of_range;

  modport source (output valid, status, temp_centi, humid_centi, temp_raw_word,
                  humid_raw_word, temp_out_of_range, humid_out_of_range,
                  input ready);
  modport sink   (input valid, status, temp_centi, humid_centi, temp_raw_word,
                  humid_raw_word, temp_out_of_range, humid_out_of_range,
                  output ready);
endinterface

interface htfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/htfd_front.sv]
module htfd_front import htfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  htfd_byte_if.sink   frame,
  output logic        rec_valid,
  input  logic        rec_ready,
  output frame_t      rec
);

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] temp_word, temp_word_next;
  logic [15:0] humid_word, humid_word_next;
  logic        temp_crc_bad, temp_crc_bad_next;

  logic [2:0]  pos;
  logic [7:0]  crc_in;
  logic        accept;
  logic        humid_bad;

  // only the last byte of a frame needs room in the queue
  assign frame.ready = rec_ready || (byte_position != POS_HUM_CRC);
  assign accept      = frame.valid && frame.ready;

  always_comb begin
    pos    = (frame.frame_start || byte_position > POS_HUM_CRC) ? POS_TEMP_HI : byte_position;
    crc_in = frame.frame_start ? CRC_INIT : running_crc;
  end

  assign humid_bad  = (crc_in != frame.data_byte);
  assign rec_valid  = accept && (pos == POS_HUM_CRC);
  assign rec.temp_bits  = temp_word;
  assign rec.humid_bits = humid_word;
  assign rec.status = temp_crc_bad ? ST_TEMP_CRC : (humid_bad ? ST_HUMID_CRC : ST_OK);

  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    temp_word_next     = temp_word;
    humid_word_next    = humid_word;
    temp_crc_bad_next  = temp_crc_bad;
    if (accept) begin
      byte_position_next = pos + 3'd1;
      unique case (pos)
        POS_TEMP_HI: begin
          temp_word_next   = {frame.data_byte, 8'h00};
          running_crc_next = crc8_feed(crc_in, frame.data_byte);
        end
        POS_TEMP_LO: begin
          temp_word_next   = {temp_word[15:8], frame.data_byte};
          running_crc_next = crc8_feed(crc_in, frame.data_byte);
        end
        POS_TEMP_CRC: begin
          temp_crc_bad_next = humid_bad;
          running_crc_next  = CRC_INIT;
        end
        POS_HUM_HI: begin
          humid_word_next  = {frame.data_byte, 8'h00};
          running_crc_next = crc8_feed(crc_in, frame.data_byte);
        end
        POS_HUM_LO: begin
          humid_word_next  = {humid_word[15:8], frame.data_byte};
          running_crc_next = crc8_feed(crc_in, frame.data_byte);
        end
        default: begin
          running_crc_next   = CRC_INIT;
          temp_crc_bad_next  = 1'b0;
          byte_position_next = POS_TEMP_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_TEMP_HI;
      running_crc   <= CRC_INIT;
      temp_crc_bad  <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      temp_crc_bad  <= temp_crc_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    temp_word  <= temp_word_next;
    humid_word <= humid_word_next;
  end

endmodule

[rtl/htfd_queue.sv]
module htfd_queue import htfd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  frame_t in_rec,
  output logic   out_valid,
  input  logic   out_ready,
  output frame_t out_rec
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  frame_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_rec   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_rec;
    end
  end

endmodule

[rtl/htfd_back.sv]
module htfd_back import htfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         rec_valid,
  output logic         rec_ready,
  input  frame_t       rec,
  input  limits_t      lim,
  htfd_result_if.source result
);

  logic               adv;

  logic               s1_valid;
  frame_t             s1_rec;
  logic [30:0]        s1_tp;
  logic [29:0]        s1_hp;

  logic               s2_valid;
  frame_t             s2_rec;
  logic signed [14:0] s2_t;
  logic [13:0]        s2_h;

  logic [14:0]        tq0, tq;
  logic [16:0]        tsum;
  logic [13:0]        hq0, hq;
  logic [16:0]        hsum;
  logic signed [15:0] tfull;
  logic               ok, tf, hf;

  assign adv       = !result.valid || result.ready;
  assign rec_ready = adv;

  // floor(x / 65535) = floor(x / 65536) plus one when the remainder spills over
  always_comb begin
    tq0   = s1_tp[30:16];
    tsum  = {1'b0, s1_tp[15:0]} + {2'b00, tq0};
    tq    = tq0 + 15'(tsum >= RAW_FULL);
    tfull = $signed({1'b0, tq}) + TEMP_OFFSET;
    hq0   = s1_hp[29:16];
    hsum  = {1'b0, s1_hp[15:0]} + {3'b000, hq0};
    hq    = hq0 + 14'(hsum >= RAW_FULL);
  end

  always_comb begin
    ok = (s2_rec.status == ST_OK);
    tf = ok && (s2_t < lim.temp_min || s2_t > lim.temp_max);
    hf = ok && (s2_h < lim.humid_min || s2_h > lim.humid_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= rec_valid;
      s2_valid     <= s1_valid;
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rec <= rec;
      s1_tp  <= 31'(rec.temp_bits) * 31'(TEMP_SPAN);
      s1_hp  <= 30'(rec.humid_bits) * 30'(HUMID_SPAN);

      s2_rec <= s1_rec;
      s2_t   <= tfull[14:0];
      s2_h   <= hq;

      result.status             <= s2_rec.status;
      result.temp_centi         <= ok ? s2_t : '0;
      result.humid_centi        <= ok ? s2_h : '0;
      result.temp_raw_word      <= s2_rec.temp_bits;
      result.humid_raw_word     <= s2_rec.humid_bits;
      result.temp_out_of_range  <= tf;
      result.humid_out_of_range <= hf;
    end
  end

endmodule

[rtl/humidity_temp_frame_decoder.sv]
// channel  | role | payload
// frame    | sink | data_byte[7:0], frame_start
// result   | src  | status, temp/humid centi, raw words, range flags
// cfg      | sink | index[1:0], data[14:0], always ready
//
// One byte per cycle while frame.ready holds. A frame result passes the frame queue,
// then multiply, divide-by-65535 correction, limit compare into the output register.
// Synchronous reset clears frame position, CRC and the queue; limits to defaults.
// The converter stalls as a whole on result backpressure; the frame queue lets
// bytes keep flowing until it fills, then the sixth byte of a frame waits.
module humidity_temp_frame_decoder import htfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  htfd_byte_if.sink     frame,
  htfd_result_if.source result,
  htfd_cfg_if.sink      cfg
);

`include "humidity_temp_frame_decoder_macros.svh"

  limits_t lim;
  logic    fq_valid, fq_ready, bq_valid, bq_ready;
  frame_t  fq_rec, bq_rec;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.temp_min  <= TEMP_MIN_RST;
      lim.temp_max  <= TEMP_MAX_RST;
      lim.humid_min <= HUMID_MIN_RST;
      lim.humid_max <= HUMID_MAX_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_TEMP_MIN:  lim.temp_min  <= $signed(cfg.data);
        REG_TEMP_MAX:  lim.temp_max  <= $signed(cfg.data);
        REG_HUMID_MIN: lim.humid_min <= cfg.data[13:0];
        REG_HUMID_MAX: lim.humid_max <= cfg.data[13:0];
      endcase
    end
  end

  htfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .rec_valid (fq_valid),
    .rec_ready (fq_ready),
    .rec       (fq_rec)
  );

  htfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_rec    (fq_rec),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_rec   (bq_rec)
  );

  htfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (bq_valid),
    .rec_ready (bq_ready),
    .rec       (bq_rec),
    .lim       (lim),
    .result    (result)
  );

  `HTFD_ASSERT_IMPL(a_bad_zeroed, result.valid && result.status != ST_OK,
                    result.temp_centi == '0 && result.humid_centi == '0 &&
                    !result.temp_out_of_range && !result.humid_out_of_range,
                    "bad frame with nonzero fields")
  `HTFD_ASSERT_IMPL(a_humid_span, result.valid && result.status == ST_OK,
                    result.humid_centi <= HUMID_SPAN, "humidity above full scale")
  `HTFD_ASSERT_NEXT(a_frame_held, fq_valid && !fq_ready, 1'b0,
                    "frame record pushed into full queue")

endmodule
